// File: hdl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared types and constants of the postfix integer evaluator: beat payloads,
// character codes, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int VALUE_WIDTH = 32;

  // character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DIVZERO = 3'd1;
  localparam logic [2:0] ST_UNDER   = 3'd2;
  localparam logic [2:0] ST_OVER    = 3'd3;
  localparam logic [2:0] ST_BADCHAR = 3'd4;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [2:0]                    status;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       do_digit;
    logic       do_dot;
    logic       push_token;
    logic       clear_token;
    logic       set_err;
    logic [2:0] err_code;
    logic       rd_second;
    logic       cap_a;
    logic       cap_b;
    logic       alu_write;
    logic       div_start;
    logic       div_step;
    logic       div_write;
    logic       out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_digit;
    logic is_dot;
    logic is_space;
    logic is_op;
    logic is_div;
    logic last;
    logic err_set;
    logic have_digits;
    logic stack_full;
    logic count_lt2;
    logic count_zero;
    logic a_zero;
    logic div_last;
    logic out_free;
  } stat_t;

endpackage

// File: hdl/postfix_integer_evaluator.sv
// per character: idle and decode for a digit, dot, space or bad character;
// + - * add operand reads and execute; / adds the one-bit-per-cycle divider and write-back
// a last character then passes flush and final check before loading the output register
// one character is in work at a time; the output register lets the next one start early
// reset (synchronous, active high) clears the stack count, token, error and output valid;
// stack contents stay undefined until pushed
// ----------------------------------------------------------------------------
// postfix_integer_evaluator
// Reverse Polish integer expression evaluator fed one character per beat,
// giving one result beat (top of stack and status) per expression.
// ----------------------------------------------------------------------------
module postfix_integer_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  rpn_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output rpn_pkg::result_t result
);
  import rpn_pkg::*;

  // command and status buses between controller and datapath
  cmd_t  cmd;
  stat_t stat;

  // state machine: decode, operand fetch, execute, divide, end of expression
  rpn_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // stack memory, token builder, arithmetic, divider and output register
  rpn_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTH
  // a beat taken moves the controller out of idle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("input taken while a character is still in work");

  // the divider never starts on a zero divisor
  a_no_div_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.a_zero)
    else $error("divider started with zero divisor");

  // a push never goes past the top of the stack
  a_no_overflow_push: assert property (@(posedge clk) disable iff (rst)
    cmd.push_token |-> !stat.stack_full)
    else $error("push onto full stack");

  // a result leaves the evaluator cleared for the next expression
  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (stat.count_zero && !stat.err_set && !stat.have_digits))
    else $error("state not cleared after result");
`endif

endmodule

// File: hdl/rpn_dp.sv
// ----------------------------------------------------------------------------
// rpn_dp
// Datapath: character register, pending token, value stack memory, operand
// registers, add/subtract/multiply unit, radix-2 divider and result register.
// ----------------------------------------------------------------------------
module rpn_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  rpn_pkg::item_t  item,
  input  rpn_pkg::cmd_t   cmd,
  output rpn_pkg::stat_t  stat,
  output logic            result_valid,
  input  logic            result_ready,
  output rpn_pkg::result_t result
);
  import rpn_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = $clog2(W);

  logic [7:0]    cur_ch;
  logic          cur_last;
  logic [W-1:0]  pending;
  logic          have_digits;
  logic          after_dot;
  logic [CW-1:0] count;
  logic [2:0]    err;
  logic [W-1:0]  a_val;
  logic [W-1:0]  b_val;

  logic [W-1:0]  stack_mem [STACK_DEPTH];
  logic [W-1:0]  mem_q;

  logic [W-1:0]  div_quo;
  logic [W-1:0]  div_rem;
  logic [W-1:0]  div_dvsr;
  logic          div_neg;
  logic [DW-1:0] div_cnt;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic [CW-1:0] rd_idx;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;
  logic          wr_en;
  logic [7:0]    digit_off;
  logic [W-1:0]  digit_val;
  logic [W-1:0]  alu_res;
  logic [W-1:0]  div_res;
  logic [W:0]    rem_sh;
  logic [W:0]    rem_diff;

  assign cnt_m1 = count - CW'(1);
  assign cnt_m2 = count - CW'(2);
  assign rd_idx = cmd.rd_second ? cnt_m2 : cnt_m1;

  assign digit_off = cur_ch - CH_ZERO;
  assign digit_val = {{(W-4){1'b0}}, digit_off[3:0]};

  // operands: a is the top, b the one below
  always_comb begin
    case (cur_ch)
      CH_PLUS:  alu_res = b_val + a_val;
      CH_MINUS: alu_res = b_val - a_val;
      default:  alu_res = W'(b_val * a_val);
    endcase
  end

  assign div_res  = div_neg ? (W'(0) - div_quo) : div_quo;
  assign rem_sh   = {div_rem, div_quo[W-1]};
  assign rem_diff = rem_sh - {1'b0, div_dvsr};

  assign wr_en   = cmd.push_token | cmd.alu_write | cmd.div_write;
  assign wr_addr = cmd.push_token ? count[AW-1:0] : cnt_m2[AW-1:0];
  assign wr_data = cmd.push_token ? pending : (cmd.alu_write ? alu_res : div_res);

  // value stack
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    mem_q <= stack_mem[rd_idx[AW-1:0]];
  end

  // character and operand registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cur_ch   <= item.ch;
      cur_last <= item.last;
    end
    if (cmd.cap_a) begin
      a_val <= mem_q;
    end
    if (cmd.cap_b) begin
      b_val <= mem_q;
    end
  end

  // divider on magnitudes, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_quo  <= b_val[W-1] ? (W'(0) - b_val) : b_val;
      div_dvsr <= a_val[W-1] ? (W'(0) - a_val) : a_val;
      div_rem  <= '0;
      div_neg  <= a_val[W-1] ^ b_val[W-1];
      div_cnt  <= '0;
    end else if (cmd.div_step) begin
      div_rem  <= rem_diff[W] ? rem_sh[W-1:0] : rem_diff[W-1:0];
      div_quo  <= {div_quo[W-2:0], ~rem_diff[W]};
      div_cnt  <= div_cnt + DW'(1);
    end
  end

  // token, stack count and error
  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      pending     <= '0;
      have_digits <= 1'b0;
      after_dot   <= 1'b0;
      count       <= '0;
      err         <= ST_OK;
    end else begin
      if (cmd.clear_token) begin
        pending     <= '0;
        have_digits <= 1'b0;
        after_dot   <= 1'b0;
      end else if (cmd.do_digit) begin
        if (!after_dot) begin
          pending <= (pending << 3) + (pending << 1) + digit_val;
        end
        have_digits <= 1'b1;
      end else if (cmd.do_dot) begin
        after_dot   <= 1'b1;
        have_digits <= 1'b1;
      end
      if (cmd.push_token) begin
        count <= count + CW'(1);
      end else if (cmd.alu_write || cmd.div_write) begin
        count <= cnt_m1;
      end
      if (cmd.set_err) begin
        err <= cmd.err_code;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.value  <= (err == ST_OK) ? mem_q : '0;
      result.status <= err;
    end
  end

  assign stat.is_digit    = (cur_ch >= CH_ZERO) && (cur_ch <= CH_NINE);
  assign stat.is_dot      = (cur_ch == CH_DOT);
  assign stat.is_space    = (cur_ch == CH_SPACE);
  assign stat.is_op       = (cur_ch == CH_PLUS) || (cur_ch == CH_MINUS) ||
                            (cur_ch == CH_STAR) || (cur_ch == CH_SLASH);
  assign stat.is_div      = (cur_ch == CH_SLASH);
  assign stat.last        = cur_last;
  assign stat.err_set     = (err != ST_OK);
  assign stat.have_digits = have_digits;
  assign stat.stack_full  = (count >= CW'(STACK_DEPTH));
  assign stat.count_lt2   = (count < CW'(2));
  assign stat.count_zero  = (count == '0);
  assign stat.a_zero      = (a_val == '0);
  assign stat.div_last    = (div_cnt == DW'(W - 1));
  assign stat.out_free    = !result_valid || result_ready;

endmodule

// File: hdl/rpn_ctrl.sv
// ----------------------------------------------------------------------------
// rpn_ctrl
// Controller: sequences one character at a time through decode, operand
// reads, arithmetic or division, and the end-of-expression steps.
// ----------------------------------------------------------------------------
module rpn_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  rpn_pkg::stat_t stat,
  output rpn_pkg::cmd_t  cmd
);
  import rpn_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_RDA    = 4'd2;
  localparam logic [3:0] S_RDB    = 4'd3;
  localparam logic [3:0] S_EXEC   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_DIVW   = 4'd6;
  localparam logic [3:0] S_FLUSH  = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] after_char;

  assign item_ready = (state == S_IDLE);
  assign after_char = stat.last ? S_FLUSH : S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = after_char;
        if (stat.err_set) begin
          // sticky error: character ignored
        end else if (stat.is_digit) begin
          cmd.do_digit = 1'b1;
        end else if (stat.is_dot) begin
          cmd.do_dot = 1'b1;
        end else if (stat.is_space) begin
          cmd.clear_token = 1'b1;
          if (stat.have_digits && stat.stack_full) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_OVER;
          end else if (stat.have_digits) begin
            cmd.push_token = 1'b1;
          end
        end else if (stat.is_op) begin
          if (stat.count_lt2) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_UNDER;
          end else begin
            state_next = S_RDA;
          end
        end else begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_BADCHAR;
        end
      end
      S_RDA: begin
        cmd.cap_a     = 1'b1;
        cmd.rd_second = 1'b1;
        state_next    = S_RDB;
      end
      S_RDB: begin
        cmd.cap_b  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.is_div) begin
          cmd.alu_write = 1'b1;
          state_next    = after_char;
        end else if (stat.a_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_DIVZERO;
          state_next   = after_char;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_DIVW;
        end
      end
      S_DIVW: begin
        cmd.div_write = 1'b1;
        state_next    = after_char;
      end
      S_FLUSH: begin
        if (!stat.err_set) begin
          cmd.clear_token = 1'b1;
          if (stat.have_digits && stat.stack_full) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_OVER;
          end else if (stat.have_digits) begin
            cmd.push_token = 1'b1;
          end
        end
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!stat.err_set && stat.count_zero) begin
          cmd.set_err  = 1'b1;
          cmd.err_code = ST_UNDER;
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
